### sv/byte_fifo_with_undo_and_delimiter_defines.svh
// ----------------------------------------------------------------------------
// Byte FIFO assertion macros
// Shared assertion macros for the byte FIFO. They expand to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef BYTE_FIFO_WITH_UNDO_AND_DELIMITER_DEFINES_SVH
`define BYTE_FIFO_WITH_UNDO_AND_DELIMITER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define BF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define BF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BF_ASSERT(lbl, prop, msg)
`define BF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/bfifo_pkg.sv
// ----------------------------------------------------------------------------
// Byte FIFO package
// Widths, command and status codes, the command queue entry and pointer
// helpers shared by the byte FIFO modules.
// ----------------------------------------------------------------------------
package bfifo_pkg;

  localparam int DEPTH       = 4096;
  localparam int MAX_BURST   = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int CNT_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int SUM_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP       = 2'd1,
    OP_UNDO      = 2'd2,
    OP_POP_UNTIL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // One decoded command as it travels from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] delim;
  } item_t;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

endpackage

### sv/bfifo_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bfifo_front.sv
// ----------------------------------------------------------------------------
// Byte FIFO command front end
// Accepts commands, decodes them, clips the count to the burst limit and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module bfifo_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [bfifo_pkg::BYTE_W-1:0] data_in,
  input  logic [bfifo_pkg::CNT_W-1:0]  count,
  input  logic [bfifo_pkg::BYTE_W-1:0] delimiter,
  output logic                        q_valid,
  output bfifo_pkg::item_t            q_item,
  input  logic                        q_pop
);
  import bfifo_pkg::*;

  item_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic [QUEUE_AW:0]   fill_next;
  logic                push_q;
  logic                pop_q;
  item_t               decoded;

  always_comb begin
    decoded.op    = op_t'(cmd);
    decoded.data  = data_in;
    decoded.delim = delimiter;
    decoded.count = (count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : count;
  end

  assign busy    = (fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign push_q  = start && !busy;
  assign q_valid = (fill != '0);
  assign pop_q   = q_pop && q_valid;
  assign q_item  = entries[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push_q && !pop_q) begin
      fill_next = fill + 1'b1;
    end else if (pop_q && !push_q) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push_q) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_q) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      entries[wr_ptr] <= decoded;
    end
  end

endmodule

### sv/bfifo_back.sv
// ----------------------------------------------------------------------------
// Byte FIFO execution back end
// Owns the ring buffer, its pointers and occupancy, and carries out one
// queued command at a time, producing registered results.
// ----------------------------------------------------------------------------
module bfifo_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  bfifo_pkg::item_t             q_item,
  output logic                         q_pop,
  output logic                         strobe,
  output logic [bfifo_pkg::BYTE_W-1:0] data_out,
  output logic                         byte_valid,
  output logic                         last,
  output logic [bfifo_pkg::CNT_W-1:0]  moved,
  output logic [1:0]                   status
);
  import bfifo_pkg::*;

`include "byte_fifo_with_undo_and_delimiter_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [PTR_W-1:0]  head_ptr, head_ptr_next;
  logic [PTR_W-1:0]  tail_ptr, tail_ptr_next;
  logic [OCC_W-1:0]  occupancy, occupancy_next;
  logic [CNT_W-1:0]  burst_len, burst_len_next;
  logic [CNT_W-1:0]  sent, sent_next;
  logic              until_mode, until_mode_next;
  logic [BYTE_W-1:0] delim, delim_next;

  logic              strobe_next;
  logic [BYTE_W-1:0] data_out_next;
  logic              byte_valid_next;
  logic              last_next;
  logic [CNT_W-1:0]  moved_next;
  logic [1:0]        status_next;

  logic              ram_we;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [CNT_W-1:0]  occ_small;
  logic [CNT_W-1:0]  n_clip;
  logic [SUM_W-1:0]  tail_wide;
  logic [SUM_W-1:0]  n_wide;
  logic [SUM_W-1:0]  tail_back;
  logic [CNT_W-1:0]  sent_inc;
  logic              stop;

  bfifo_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_ptr),
    .wdata (q_item.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The read port runs one byte ahead of the head so that EMIT sees the
  // byte at the head in every cycle.
  assign ram_raddr = (state == ST_EMIT) ? ptr_advance(head_ptr) : head_ptr;

  always_comb begin
    occ_small = (occupancy > MAX_BURST) ? CNT_W'(MAX_BURST) : CNT_W'(occupancy);
    n_clip    = (q_item.count < occ_small) ? q_item.count : occ_small;
    tail_wide = SUM_W'(tail_ptr);
    n_wide    = SUM_W'(n_clip);
    tail_back = (tail_wide >= n_wide) ? tail_wide - n_wide
                                      : tail_wide + SUM_W'(DEPTH) - n_wide;
    sent_inc  = sent + 1'b1;
    stop      = (sent_inc == burst_len) || (until_mode && (ram_rdata == delim));
  end

  always_comb begin
    state_next      = state;
    head_ptr_next   = head_ptr;
    tail_ptr_next   = tail_ptr;
    occupancy_next  = occupancy;
    burst_len_next  = burst_len;
    sent_next       = sent;
    until_mode_next = until_mode;
    delim_next      = delim;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    strobe_next     = 1'b0;
    data_out_next   = '0;
    byte_valid_next = 1'b0;
    last_next       = 1'b0;
    moved_next      = '0;
    status_next     = STAT_OK;

    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          strobe_next = 1'b1;
          last_next   = 1'b1;
          if (q_item.op == OP_PUSH) begin
            if (occupancy == OCC_W'(DEPTH)) begin
              status_next = STAT_FULL;
            end else begin
              ram_we         = 1'b1;
              tail_ptr_next  = ptr_advance(tail_ptr);
              occupancy_next = occupancy + 1'b1;
              moved_next     = CNT_W'(1);
            end
          end else if (occupancy == '0) begin
            status_next = STAT_EMPTY;
          end else if (q_item.op == OP_UNDO) begin
            tail_ptr_next  = PTR_W'(tail_back);
            occupancy_next = occupancy - OCC_W'(n_clip);
            moved_next     = n_clip;
          end else if (n_clip != '0) begin
            // A read burst: the result comes from EMIT instead.
            strobe_next     = 1'b0;
            last_next       = 1'b0;
            burst_len_next  = n_clip;
            sent_next       = '0;
            until_mode_next = (q_item.op == OP_POP_UNTIL);
            delim_next      = q_item.delim;
            state_next      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        strobe_next     = 1'b1;
        data_out_next   = ram_rdata;
        byte_valid_next = 1'b1;
        head_ptr_next   = ptr_advance(head_ptr);
        occupancy_next  = occupancy - 1'b1;
        sent_next       = sent_inc;
        if (stop) begin
          last_next  = 1'b1;
          moved_next = sent_inc;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_ptr  <= '0;
      tail_ptr  <= '0;
      occupancy <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      head_ptr  <= head_ptr_next;
      tail_ptr  <= tail_ptr_next;
      occupancy <= occupancy_next;
      strobe    <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    burst_len  <= burst_len_next;
    sent       <= sent_next;
    until_mode <= until_mode_next;
    delim      <= delim_next;
    data_out   <= data_out_next;
    byte_valid <= byte_valid_next;
    last       <= last_next;
    moved      <= moved_next;
    status     <= status_next;
  end

  `BF_ASSERT(a_occ_bound, occupancy <= OCC_W'(DEPTH), "occupancy above depth")
  `BF_ASSERT(a_emit_gives_byte, (state == ST_EMIT) |=> (strobe && byte_valid),
    "burst cycle without a byte result")
  `BF_ASSERT(a_moved_bound, strobe |-> (moved <= CNT_W'(MAX_BURST)),
    "moved count above burst limit")
  `BF_ASSERT(a_state_onehot, $onehot(state), "state register not one-hot")

endmodule

### sv/byte_fifo_with_undo_and_delimiter.sv
// ----------------------------------------------------------------------------
// Byte FIFO with undo and delimiter
// Ring-buffer byte FIFO with push, pop, undo from the tail and pop until a
// delimiter, each command reporting how many bytes it moved.
// ----------------------------------------------------------------------------
//
// Channel   Handshake            Signals
// -------   ------------------   ----------------------------------------------
// command   start & !busy        cmd, data_in, count, delimiter
// result    strobe (no stall)    data_out, byte_valid, last, moved, status
//
// Push, undo, pops with a zero count and commands that find the FIFO empty
// each give one result; a run of pushes is taken at one per cycle while no
// read burst is running. A pop or pop-until of n bytes first sets up the
// read port of the byte store, then one byte leaves per cycle in EMIT.
// Each command is registered in the command queue before the back end sees it.
// Reset (rst, synchronous) empties the FIFO; the byte store itself is not
// cleared, and no clearing pass is needed since only occupied bytes are read.
// The receiver cannot stall results; busy rises only when the command queue
// is full while a read burst is still running.
//
module byte_fifo_with_undo_and_delimiter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic [bfifo_pkg::BYTE_W-1:0] data_in,
  input  logic [bfifo_pkg::CNT_W-1:0]  count,
  input  logic [bfifo_pkg::BYTE_W-1:0] delimiter,
  output logic                         strobe,
  output logic [bfifo_pkg::BYTE_W-1:0] data_out,
  output logic                         byte_valid,
  output logic                         last,
  output logic [bfifo_pkg::CNT_W-1:0]  moved,
  output logic [1:0]                   status
);
  import bfifo_pkg::*;

  // Decoded commands waiting for the back end. The queue lets a new
  // transaction be taken while a read burst is still emitting bytes.
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // The front end decodes each command transaction and clips its count to
  // the burst limit; everything that depends on the FIFO state is left to
  // the back end, which sees the state as it stands when the command runs.
  bfifo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .data_in   (data_in),
    .count     (count),
    .delimiter (delimiter),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // The back end holds the byte store, the head and tail pointers and the
  // occupancy. It clips the count to the occupancy, updates the pointers
  // and drives every result from registers, so each result transaction is
  // on the ports for exactly one cycle.
  bfifo_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .strobe     (strobe),
    .data_out   (data_out),
    .byte_valid (byte_valid),
    .last       (last),
    .moved      (moved),
    .status     (status)
  );

endmodule
